// ----- hw/rtl/rcaf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcaf_pkg
// Shared types, codes and width helpers for the remainder / compare ALU.
// ----------------------------------------------------------------------------
package rcaf_pkg;

    localparam int DATA_W = 32;

    // instruction codes
    localparam logic ACT_MOD = 1'b0;
    localparam logic ACT_CMP = 1'b1;

    // width codes; the spare code behaves as 32 bits
    localparam logic [1:0] WID_8  = 2'd0;
    localparam logic [1:0] WID_16 = 2'd1;
    localparam logic [1:0] WID_32 = 2'd2;

    // status flag positions
    localparam int FLG_ZERO = 0;
    localparam int FLG_NEG  = 1;
    localparam int FLG_ODD  = 2;
    localparam int FLG_BOR  = 3;
    localparam int FLG_OVF  = 4;
    localparam int FLG_W    = 5;

    // one input word, unpacked from the stream
    typedef struct packed {
        logic              action;
        logic [1:0]        op_width;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [1:0]        b_width;
        logic              b_signed;
    } rcaf_in_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } rcaf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_mod;
        logic div_zero;
        logic out_free;
    } rcaf_sts_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
        logic [DATA_W-1:0] m;
        case (code)
            WID_8:   m = DATA_W'(32'h0000_00FF);
            WID_16:  m = DATA_W'(32'h0000_FFFF);
            WID_32:  m = '1;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] sign_bit(input logic [1:0] code);
        logic [DATA_W-1:0] s;
        case (code)
            WID_8:   s = DATA_W'(32'h0000_0080);
            WID_16:  s = DATA_W'(32'h0000_8000);
            WID_32:  s = DATA_W'(32'h8000_0000);
            default: s = DATA_W'(32'h8000_0000);
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/remainder_compare_alu_flags_top.sv -----
// ----------------------------------------------------------------------------
// remainder_compare_alu_flags_top
// Unsigned remainder and compare ALU at 8, 16 or 32 bits with status flags.
//
//   channel | dir | tdata                                   | tuser
//   --------+-----+-----------------------------------------+-----------------
//   s_      | in  | op_width, operand_a, operand_b, b_width,| action
//           |     | b_signed                                |
//   m_      | out | result                                  | write_back,
//           |     |                                         | divide_by_zero,
//           |     |                                         | five flags
//
// A mod passes from the input word to the result word through a decision
// state, 32 steps of the radix-2 divider and a commit state. Compare and a
// zero divisor skip the divider. One word is in flight at a time; the next
// input word is taken as soon as the result sits in the output register.
// Reset (aresetn low, synchronous) empties the output register and clears
// the flags. A stalled output holds the commit until the register is free.
// ----------------------------------------------------------------------------
module remainder_compare_alu_flags_top #(
    parameter int DATA_WIDTH = rcaf_pkg::DATA_W
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // op_width[1:0], operand_a, operand_b, b_width[1:0], b_signed, zero pad
    input  logic [((2*DATA_WIDTH+12)/8)*8-1:0]     s_tdata,
    // action
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // result
    output logic [DATA_WIDTH-1:0]                  m_tdata,
    // write_back, divide_by_zero, flag_zero, flag_negative, flag_odd,
    // flag_borrow, flag_overflow
    output logic [6:0]                             m_tuser
);
    import rcaf_pkg::*;

    localparam int A_LO = 2;
    localparam int B_LO = A_LO + DATA_WIDTH;
    localparam int W_LO = B_LO + DATA_WIDTH;

    rcaf_in_t  in_word;
    rcaf_cmd_t cmd;
    rcaf_sts_t sts;

    // unpack the input word
    always_comb begin
        in_word.action    = s_tuser;
        in_word.op_width  = s_tdata[1:0];
        in_word.operand_a = DATA_W'(s_tdata[B_LO-1:A_LO]);
        in_word.operand_b = DATA_W'(s_tdata[W_LO-1:B_LO]);
        in_word.b_width   = s_tdata[W_LO+1:W_LO];
        in_word.b_signed  = s_tdata[W_LO+2];
    end

    rcaf_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcaf_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (in_word),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_tdata),
        .m_info   (m_tuser)
    );

endmodule

// ----- hw/rtl/rcaf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcaf_ctrl
// Sequencer: takes a word, steps the divider for a mod with a nonzero divisor, commits the result.
// ----------------------------------------------------------------------------
module rcaf_ctrl #(
    parameter int DATA_WIDTH = rcaf_pkg::DATA_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rcaf_pkg::rcaf_sts_t sts,
    output rcaf_pkg::rcaf_cmd_t cmd
);
    import rcaf_pkg::*;

    localparam int              CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // commands
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tready && s_tvalid;
    assign cmd.step   = (state_reg == ST_DIVIDE);
    assign cmd.commit = (state_reg == ST_COMMIT) && sts.out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cnt_next = '0;
                if (sts.is_mod && !sts.div_zero) state_next = ST_DIVIDE;
                else                             state_next = ST_COMMIT;
            end
            ST_DIVIDE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // a taken word always goes to the decision cycle
    a_load_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_DECIDE))
        else $error("word taken but controller did not decide");

    // the last divider step hands over to commit
    a_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && cnt_reg == CNT_LAST) |=> (state_reg == ST_COMMIT))
        else $error("divider ran past its last step");

    // zero divisor and compare skip the divider
    a_no_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && (!sts.is_mod || sts.div_zero))
            |=> (state_reg == ST_COMMIT))
        else $error("divider started without a valid divisor");
`endif

endmodule

// ----- hw/rtl/rcaf_dpath.sv -----
// ----------------------------------------------------------------------------
// rcaf_dpath
// Operand preparation, radix-2 restoring divider, compare, flags and the
// output register.
// ----------------------------------------------------------------------------
module rcaf_dpath #(
    parameter int DATA_WIDTH = rcaf_pkg::DATA_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rcaf_pkg::rcaf_in_t      in_word,
    input  rcaf_pkg::rcaf_cmd_t     cmd,
    output rcaf_pkg::rcaf_sts_t     sts,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_WIDTH-1:0]   m_result,
    output logic [6:0]              m_info
);
    import rcaf_pkg::*;

    // prepared operands
    logic [DATA_WIDTH-1:0] a_reg, b_reg, mask_reg, sgn_reg;
    logic                  action_reg;
    logic [DATA_WIDTH-1:0] op_mask, op_sgn, b_mask, b_sgn, b_ext, a_in;

    // divider
    logic [DATA_WIDTH-1:0] rem_reg, dvd_reg;
    logic [DATA_WIDTH:0]   rem_sh, rem_try;

    // results
    logic [FLG_W-1:0]      flags_reg, flags_next;
    logic [DATA_WIDTH-1:0] res_next, diff;
    logic                  wb_next, dz_next;
    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic                  wb_reg, dz_reg;

    // operand masking and extension of the second operand
    always_comb begin
        op_mask = DATA_WIDTH'(width_mask(in_word.op_width));
        op_sgn  = DATA_WIDTH'(sign_bit(in_word.op_width));
        b_mask  = DATA_WIDTH'(width_mask(in_word.b_width));
        b_sgn   = DATA_WIDTH'(sign_bit(in_word.b_width));
        a_in    = DATA_WIDTH'(in_word.operand_a) & op_mask;
        b_ext   = DATA_WIDTH'(in_word.operand_b) & b_mask;
        if (in_word.b_signed && ((b_ext & b_sgn) != '0)) b_ext = b_ext | ~b_mask;
        b_ext   = b_ext & op_mask;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg      <= a_in;
            b_reg      <= b_ext;
            mask_reg   <= op_mask;
            sgn_reg    <= op_sgn;
            action_reg <= in_word.action;
        end
    end

    assign sts.is_mod   = (action_reg == ACT_MOD);
    assign sts.div_zero = (b_reg == '0);
    assign sts.out_free = !m_valid_reg || m_tready;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, dvd_reg[DATA_WIDTH-1]};
    assign rem_try = rem_sh - {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg <= '0;
            dvd_reg <= a_in;
        end else if (cmd.step) begin
            dvd_reg <= {dvd_reg[DATA_WIDTH-2:0], 1'b0};
            rem_reg <= rem_try[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0]
                                           : rem_try[DATA_WIDTH-1:0];
        end
    end

    // result and flags at commit
    assign diff = (a_reg - b_reg) & mask_reg;

    always_comb begin
        flags_next = flags_reg;
        res_next   = '0;
        wb_next    = 1'b0;
        dz_next    = 1'b0;
        if (action_reg == ACT_MOD) begin
            if (b_reg == '0) begin
                dz_next = 1'b1;
            end else begin
                res_next = rem_reg & mask_reg;
                wb_next  = 1'b1;
            end
        end else begin
            res_next = diff;
            flags_next[FLG_BOR] = (diff > a_reg);
            flags_next[FLG_OVF] = (((a_reg & sgn_reg) != (b_reg & sgn_reg)) &&
                                   ((b_reg & sgn_reg) == (diff & sgn_reg)));
        end
        // zero divisor leaves all flags alone
        if (!dz_next) begin
            flags_next[FLG_ZERO] = (res_next == '0);
            flags_next[FLG_NEG]  = ((res_next & sgn_reg) != '0);
            flags_next[FLG_ODD]  = res_next[0];
        end
    end

    // control state of the output register and the flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            flags_reg   <= '0;
        end else begin
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                flags_reg   <= flags_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_reg <= res_next;
            wb_reg  <= wb_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;
    assign m_info   = {flags_reg[FLG_OVF], flags_reg[FLG_BOR], flags_reg[FLG_ODD],
                       flags_reg[FLG_NEG], flags_reg[FLG_ZERO], dz_reg, wb_reg};

`ifndef SYNTHESIS
    // a write-back and a divide error never appear together
    a_wb_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(wb_reg && dz_reg))
        else $error("write-back raised with divide error");

    // a compare never writes back
    a_cmp_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && action_reg == ACT_CMP) |=> !wb_reg)
        else $error("compare produced a write-back");

    // a zero divisor leaves the flags untouched
    a_dz_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && dz_next) |=> (flags_reg == $past(flags_reg)))
        else $error("flags changed on divide error");
`endif

endmodule
